[sv/fpdb_pkg.sv]
// Package for the frame power dB meter: payload structs, engine handshake
// structs, state enums and fixed constants. No dependencies.
`timescale 1ns / 1ps

package fpdb_pkg;

	localparam int SAMPLE_W = 16;
	localparam int REF_W = 15;
	localparam int ENERGY_W = 43;
	localparam int LEVEL_W = 16;

	localparam logic [REF_W-1:0] REF_RESET = 15'h7FFF;
	localparam int FLOOR_Q8 = -32512;
	localparam int CEIL_Q8 = 23296;
	localparam int DB_PER_LOG2_Q16 = 197283;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       frame_end;
	} item_t;

	typedef struct packed {
		logic signed [LEVEL_W-1:0] level_db_q8;
		logic                      floor_hit;
	} result_t;

	typedef struct packed {
		logic                start;
		logic [ENERGY_W-1:0] energy;
		logic [ENERGY_W-1:0] count;
		logic [REF_W-1:0]    ref_level;
	} eng_req_t;

	typedef struct packed {
		logic                      done;
		logic signed [LEVEL_W-1:0] level;
		logic                      floor_hit;
	} eng_rsp_t;

	typedef enum logic [1:0] {
		ST_ACC,
		ST_WAIT,
		ST_RUN
	} core_state_t;

	typedef enum logic [2:0] {
		ENG_IDLE,
		ENG_NORM,
		ENG_MUL,
		ENG_SQ,
		ENG_ACCUM,
		ENG_SCALE,
		ENG_ROUND,
		ENG_DONE
	} eng_state_t;

	typedef enum logic [1:0] {
		OP_ENERGY,
		OP_COUNT,
		OP_REF
	} eng_op_t;

endpackage

[sv/frame_power_db_meter_core.sv]
// Frame power dB meter: one sample beat per cycle while a frame accumulates.
// After the frame_end beat, ready stays low until the result is valid; zero energy
// or a zero reference skips the logarithms, else the wait is set by the
// leading-one walks and sixteen squarings per logarithm.
// A result left waiting in the output register holds off the next log pass.
// Asynchronous active-low reset clears sums and control; the reference resets to full scale.
`timescale 1ns / 1ps

module frame_power_db_meter_core #(
	parameter int MAX_FRAME = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  fpdb_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output fpdb_pkg::result_t result,
	input  logic              cfg_we,
	input  logic [fpdb_pkg::REF_W-1:0] cfg_wdata
);

	localparam int EW = fpdb_pkg::ENERGY_W;
	localparam int CNT_W = $clog2(MAX_FRAME + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME);

	fpdb_pkg::core_state_t state_q, state_d;
	fpdb_pkg::eng_req_t    req;
	fpdb_pkg::eng_rsp_t    rsp;

	logic [fpdb_pkg::REF_W-1:0] ref_q;
	logic [EW-1:0]              energy_q;
	logic [CNT_W-1:0]           count_q;
	logic [30:0]                sq_s1;
	logic                       add_s1;
	logic                       last_s1;
	logic                       accept;
	logic signed [31:0]         sq_full;
	logic [EW:0]                sum;
	logic                       finish;
	logic                       eng_start;
	fpdb_pkg::result_t          result_q;
	logic                       result_valid_q;

	assign item_ready = (state_q == fpdb_pkg::ST_ACC) && !last_s1;
	assign accept = item_valid && item_ready;
	assign sq_full = item.sample * item.sample;
	assign sum = {1'b0, energy_q} + (EW+1)'(sq_s1);
	assign finish = (state_q == fpdb_pkg::ST_RUN) && rsp.done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= fpdb_pkg::REF_RESET;
		end else if (cfg_we) begin
			ref_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpdb_pkg::ST_ACC;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		eng_start = 1'b0;
		case (state_q)
			fpdb_pkg::ST_ACC: begin
				if (last_s1) begin
					state_d = fpdb_pkg::ST_WAIT;
				end
			end
			fpdb_pkg::ST_WAIT: begin
				// The engine starts only once the output register is free.
				if (!result_valid_q) begin
					eng_start = 1'b1;
					state_d = fpdb_pkg::ST_RUN;
				end
			end
			fpdb_pkg::ST_RUN: begin
				if (rsp.done) begin
					state_d = fpdb_pkg::ST_ACC;
				end
			end
			default: state_d = fpdb_pkg::ST_ACC;
		endcase
	end

	assign req.start = eng_start;
	assign req.energy = energy_q;
	assign req.count = EW'(count_q);
	assign req.ref_level = ref_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_s1 <= 1'b0;
			last_s1 <= 1'b0;
			count_q <= '0;
		end else begin
			add_s1 <= accept && (count_q < MAX_CNT);
			last_s1 <= accept && item.frame_end;
			if (finish) begin
				count_q <= '0;
			end else if (accept && (count_q < MAX_CNT)) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		sq_s1 <= sq_full[30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q <= '0;
		end else if (finish) begin
			energy_q <= '0;
		end else if (add_s1) begin
			energy_q <= sum[EW] ? {EW{1'b1}} : sum[EW-1:0];
		end
	end

	fpdb_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (finish) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			result_q.level_db_q8 <= rsp.level;
			result_q.floor_hit <= rsp.floor_hit;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

[sv/fpdb_engine.sv]
// Log-domain level engine: three base-2 logarithms through one shared
// multiplier, then scaling to Q8 dB with rounding and clamping.
// Depends on fpdb_pkg.
`timescale 1ns / 1ps

module fpdb_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  fpdb_pkg::eng_req_t req,
	output fpdb_pkg::eng_rsp_t rsp
);

	localparam int EW = fpdb_pkg::ENERGY_W;
	localparam int D_W = 25;
	localparam int MUL_W = 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int RND_W = 48;
	localparam int LVL_W = 24;
	localparam logic [5:0] POS_TOP = 6'(EW - 1);
	localparam logic signed [LVL_W-1:0] LVL_FLOOR = LVL_W'(fpdb_pkg::FLOOR_Q8);
	localparam logic signed [LVL_W-1:0] LVL_CEIL = LVL_W'(fpdb_pkg::CEIL_Q8);
	localparam logic signed [MUL_W-1:0] DB_K = MUL_W'(fpdb_pkg::DB_PER_LOG2_Q16);
	localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(64'sd8388608);

	fpdb_pkg::eng_state_t state_q, state_d;
	fpdb_pkg::eng_op_t    op_q;

	logic [EW-1:0]              norm_q;
	logic [5:0]                 pos_q;
	logic [31:0]                m_q;
	logic [15:0]                frac_q;
	logic [3:0]                 iter_q;
	logic signed [D_W-1:0]      d_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [fpdb_pkg::LEVEL_W-1:0] level_q;
	logic                       floor_q;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	logic [32:0]              sq;
	logic [D_W-1:0]           log_val;
	logic signed [RND_W-1:0]  rnd;
	logic signed [LVL_W-1:0]  lvl;
	logic                     trivial;

	// One multiplier serves both the mantissa squaring and the dB scaling.
	always_comb begin
		if (state_q == fpdb_pkg::ENG_SCALE) begin
			mul_a = {{(MUL_W-D_W){d_q[D_W-1]}}, d_q};
			mul_b = DB_K;
		end else begin
			mul_a = {1'b0, m_q};
			mul_b = {1'b0, m_q};
		end
	end

	assign prod = mul_a * mul_b;
	assign sq = prod_q[63:31];
	assign log_val = {3'b000, pos_q, frac_q};
	assign rnd = prod_q[RND_W-1:0] + RND_HALF;
	assign lvl = rnd[RND_W-1:RND_W-LVL_W];
	assign trivial = (req.energy == '0) || (req.ref_level == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpdb_pkg::ENG_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fpdb_pkg::ENG_IDLE: begin
				if (req.start) begin
					state_d = trivial ? fpdb_pkg::ENG_DONE : fpdb_pkg::ENG_NORM;
				end
			end
			fpdb_pkg::ENG_NORM: begin
				if (norm_q[EW-1]) begin
					state_d = fpdb_pkg::ENG_MUL;
				end
			end
			fpdb_pkg::ENG_MUL: state_d = fpdb_pkg::ENG_SQ;
			fpdb_pkg::ENG_SQ: begin
				state_d = (iter_q == 4'hF) ? fpdb_pkg::ENG_ACCUM : fpdb_pkg::ENG_MUL;
			end
			fpdb_pkg::ENG_ACCUM: begin
				state_d = (op_q == fpdb_pkg::OP_REF) ? fpdb_pkg::ENG_SCALE
				                                     : fpdb_pkg::ENG_NORM;
			end
			fpdb_pkg::ENG_SCALE: state_d = fpdb_pkg::ENG_ROUND;
			fpdb_pkg::ENG_ROUND: state_d = fpdb_pkg::ENG_DONE;
			fpdb_pkg::ENG_DONE: state_d = fpdb_pkg::ENG_IDLE;
			default: state_d = fpdb_pkg::ENG_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			fpdb_pkg::ENG_IDLE: begin
				op_q <= fpdb_pkg::OP_ENERGY;
				norm_q <= req.energy;
				pos_q <= POS_TOP;
				level_q <= fpdb_pkg::LEVEL_W'(fpdb_pkg::FLOOR_Q8);
				floor_q <= 1'b1;
			end
			fpdb_pkg::ENG_NORM: begin
				// The leading one is walked up to the top bit, one place a cycle.
				if (norm_q[EW-1]) begin
					m_q <= norm_q[EW-1:EW-32];
					frac_q <= '0;
					iter_q <= '0;
				end else begin
					norm_q <= {norm_q[EW-2:0], 1'b0};
					pos_q <= pos_q - 6'd1;
				end
			end
			fpdb_pkg::ENG_MUL: prod_q <= prod;
			fpdb_pkg::ENG_SQ: begin
				frac_q <= {frac_q[14:0], sq[32]};
				m_q <= sq[32] ? sq[32:1] : sq[31:0];
				iter_q <= iter_q + 4'd1;
			end
			fpdb_pkg::ENG_ACCUM: begin
				pos_q <= POS_TOP;
				case (op_q)
					fpdb_pkg::OP_ENERGY: begin
						d_q <= $signed(log_val);
						op_q <= fpdb_pkg::OP_COUNT;
						norm_q <= req.count;
					end
					fpdb_pkg::OP_COUNT: begin
						d_q <= d_q - $signed(log_val);
						op_q <= fpdb_pkg::OP_REF;
						norm_q <= EW'(req.ref_level);
					end
					default: begin
						d_q <= d_q - $signed({log_val[D_W-2:0], 1'b0});
					end
				endcase
			end
			fpdb_pkg::ENG_SCALE: prod_q <= prod;
			fpdb_pkg::ENG_ROUND: begin
				if (lvl <= LVL_FLOOR) begin
					level_q <= LVL_FLOOR[fpdb_pkg::LEVEL_W-1:0];
					floor_q <= 1'b1;
				end else if (lvl > LVL_CEIL) begin
					level_q <= LVL_CEIL[fpdb_pkg::LEVEL_W-1:0];
					floor_q <= 1'b0;
				end else begin
					level_q <= lvl[fpdb_pkg::LEVEL_W-1:0];
					floor_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.done = (state_q == fpdb_pkg::ENG_DONE);
	assign rsp.level = level_q;
	assign rsp.floor_hit = floor_q;

endmodule

[sv/fpdb_checker.sv]
// Port-level checks for the frame power dB meter, bound to the top level.
// Depends on fpdb_pkg and frame_power_db_meter_core.
`timescale 1ns / 1ps

module fpdb_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input fpdb_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_ready,
	input fpdb_pkg::result_t result
);

	// A closing beat stops intake while the frame level is worked out.
	a_close_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && item.frame_end) |=> !item_ready)
		else $error("input still ready after frame_end beat");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> (result_valid && $stable(result)))
		else $error("result beat changed before it was taken");

	a_floor_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.floor_hit == (result.level_db_q8 == fpdb_pkg::FLOOR_Q8)))
		else $error("floor flag does not match the floor level");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result.level_db_q8 >= fpdb_pkg::FLOOR_Q8)
		               && (result.level_db_q8 <= fpdb_pkg::CEIL_Q8)))
		else $error("level outside the clamp range");

endmodule

bind frame_power_db_meter_core fpdb_checker u_fpdb_checker (.*);
